[design/four_neighbour_peak_clamp_defines.svh]
// Assertion macros for the peak clamp verification code.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FOUR_NEIGHBOUR_PEAK_CLAMP_DEFINES_SVH
`define FOUR_NEIGHBOUR_PEAK_CLAMP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FNPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnpc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FNPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fnpc check failed");

// Next-cycle implication that is also checked across reset.
`define FNPC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fnpc check failed");

`endif

[design/fnpc_pkg.sv]
// Package for the four-neighbour peak clamp: default sizes, register
// constants and command codes. No dependencies.
package fnpc_pkg;

  localparam int unsigned DEF_MAX_WIDTH   = 1024;
  localparam int unsigned DEF_PIXEL_BITS  = 16;

  localparam int unsigned CFG_WIDTH_BITS  = 11;
  localparam logic [CFG_WIDTH_BITS-1:0] CFG_WIDTH_RESET = 11'd64;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

endpackage

[design/fnpc_channels.sv]
// Valid/ready channel interfaces of the peak clamp: pixel input,
// result output and image width configuration. Depends on fnpc_pkg.
interface fnpc_in_if #(
  parameter int unsigned PIXEL_BITS = fnpc_pkg::DEF_PIXEL_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface fnpc_out_if #(
  parameter int unsigned PIXEL_BITS = fnpc_pkg::DEF_PIXEL_BITS
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface fnpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fnpc_pkg::CFG_WIDTH_BITS-1:0] image_width;

  modport source (output valid, output image_width, input ready);
  modport sink   (input valid, input image_width, output ready);
endinterface

[design/fnpc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. A read of the address being written returns old data.
module fnpc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/fnpc_out_q.sv]
// Two-entry result queue that drives the output channel, so the
// pipeline keeps moving while a result waits. Depends on fnpc_channels.
module fnpc_out_q #(
  parameter int unsigned PIXEL_BITS = fnpc_pkg::DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [PIXEL_BITS-1:0] push_pixel,
  input  logic                  push_end,
  output logic                  has_space,
  fnpc_out_if.source            out_chan
);

  logic [1:0]            count_r, count_nxt;
  logic [PIXEL_BITS-1:0] head_pix_r, tail_pix_r;
  logic                  head_end_r, tail_end_r;
  logic                  pop;

  assign pop       = (count_r != 2'd0) && out_chan.ready;
  assign has_space = (count_r != 2'd2);

  assign out_chan.valid     = (count_r != 2'd0);
  assign out_chan.pixel_out = head_pix_r;
  assign out_chan.frame_end = head_end_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Push is only offered while the queue has space, so a full queue only pops.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count_r == 2'd2) begin
        head_pix_r <= tail_pix_r;
        head_end_r <= tail_end_r;
      end else if (push) begin
        head_pix_r <= push_pixel;
        head_end_r <= push_end;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        head_pix_r <= push_pixel;
        head_end_r <= push_end;
      end else begin
        tail_pix_r <= push_pixel;
        tail_end_r <= push_end;
      end
    end
  end

endmodule

[design/four_neighbour_peak_clamp.sv]
// Four-neighbour peak clamp over a raster image, output one row behind.
// A result is registered in the s1 stage and then in the result queue.
// Throughput: one transaction per cycle while the result queue has space,
// set by the single read port of the line memory that holds the two
// previous rows per column. Reset clears the control state and loads an
// image width of 64; the line memory is not cleared.
module four_neighbour_peak_clamp #(
  parameter int unsigned MAX_WIDTH  = fnpc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned PIXEL_BITS = fnpc_pkg::DEF_PIXEL_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  fnpc_cfg_if.sink    cfg_chan,
  fnpc_in_if.sink     in_chan,
  fnpc_out_if.source  out_chan
);

  localparam int unsigned COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CFG_BITS   = fnpc_pkg::CFG_WIDTH_BITS;
  localparam int unsigned CMP_BITS   = (COL_BITS + 1 > CFG_BITS) ? COL_BITS + 1 : CFG_BITS;
  localparam int unsigned ENTRY_BITS = 2 * PIXEL_BITS;

  logic [CFG_BITS-1:0]   width_r;
  logic [COL_BITS-1:0]   col_r, col_nxt, col_inc;
  logic [1:0]            rows_r, rows_nxt;
  logic [PIXEL_BITS-1:0] left_r;
  logic                  fwd_r;
  logic [ENTRY_BITS-1:0] fwd_data_r;

  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_center_r, s1_part_r;
  logic                  s1_use_right_r, s1_end_r;

  logic [CMP_BITS-1:0]   width_wide, width_eff;
  logic                  last, is_drain, has_row, want_out;
  logic                  accept, q_space, s1_move, wr_en;
  logic [ENTRY_BITS-1:0] ram_rdata, entry, wr_data;
  logic [PIXEL_BITS-1:0] center_new, center_old;
  logic [PIXEL_BITS-1:0] below, older_use, left_use, part_a, part;
  logic [PIXEL_BITS-1:0] right_use, best, result;

  assign cfg_chan.ready = 1'b1;
  assign s1_move        = s1_valid_r && q_space;
  assign in_chan.ready  = !s1_valid_r || q_space;
  assign accept         = in_chan.valid && in_chan.ready;

  // Effective width: zero acts as one, anything above the line memory as its depth.
  assign width_wide = CMP_BITS'(width_r);
  always_comb begin
    if (width_r == '0) begin
      width_eff = CMP_BITS'(1);
    end else if (width_wide > CMP_BITS'(MAX_WIDTH)) begin
      width_eff = CMP_BITS'(MAX_WIDTH);
    end else begin
      width_eff = width_wide;
    end
  end

  assign last     = (CMP_BITS'(col_r) + CMP_BITS'(1)) >= width_eff;
  assign is_drain = (in_chan.cmd == fnpc_pkg::CMD_DRAIN);
  assign has_row  = (rows_r != 2'd0);
  assign want_out = has_row;
  assign col_inc  = col_r + COL_BITS'(1);

  // The line memory output holds the entry of this transaction's column,
  // fetched by the previous transaction; a same-cycle write to that entry
  // (one-pixel rows) is forwarded instead.
  assign entry      = fwd_r ? fwd_data_r : ram_rdata;
  assign center_new = entry[PIXEL_BITS-1:0];
  assign center_old = entry[ENTRY_BITS-1:PIXEL_BITS];

  always_comb begin
    col_nxt  = col_r;
    rows_nxt = rows_r;
    if (!is_drain) begin
      col_nxt = last ? '0 : col_inc;
      if (last && (rows_r < 2'd2)) begin
        rows_nxt = rows_r + 2'd1;
      end
    end else if (!has_row) begin
      col_nxt = '0;
    end else begin
      col_nxt = last ? '0 : col_inc;
      if (last) begin
        rows_nxt = 2'd0;
      end
    end
  end

  assign wr_en   = accept && !is_drain;
  assign wr_data = {center_new, in_chan.pixel_in};

  fnpc_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col_r),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (col_nxt),
    .rd_data (ram_rdata)
  );

  // Up, down and left neighbors are known at acceptance; only the right
  // neighbor waits for the memory read.
  assign below     = is_drain ? '0 : in_chan.pixel_in;
  assign older_use = (rows_r >= 2'd2) ? center_old : '0;
  assign left_use  = (col_r != '0) ? left_r : '0;
  assign part_a    = (older_use > below) ? older_use : below;
  assign part      = (left_use > part_a) ? left_use : part_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= fnpc_pkg::CFG_WIDTH_RESET;
      col_r      <= '0;
      rows_r     <= 2'd0;
      fwd_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        width_r <= cfg_chan.image_width;
      end
      if (accept) begin
        col_r      <= col_nxt;
        rows_r     <= rows_nxt;
        fwd_r      <= wr_en && (col_r == col_nxt);
        s1_valid_r <= want_out;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r     <= wr_data;
      s1_center_r    <= center_new;
      s1_part_r      <= part;
      s1_use_right_r <= !last;
      s1_end_r       <= is_drain && last;
      if (!is_drain || has_row) begin
        left_r <= center_new;
      end
    end
  end

  assign right_use = s1_use_right_r ? entry[PIXEL_BITS-1:0] : '0;
  assign best      = (right_use > s1_part_r) ? right_use : s1_part_r;
  assign result    = (s1_center_r < best) ? s1_center_r : best;

  fnpc_out_q #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_move),
    .push_pixel (result),
    .push_end   (s1_end_r),
    .has_space  (q_space),
    .out_chan   (out_chan)
  );

endmodule

[design/fnpc_checker.sv]
// Port-level checks for the peak clamp, bound to the top level.
// Depends on four_neighbour_peak_clamp_defines.svh and the channel interfaces.
`include "four_neighbour_peak_clamp_defines.svh"

module fnpc_checker #(
  parameter int unsigned PIXEL_BITS = fnpc_pkg::DEF_PIXEL_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIXEL_BITS-1:0] pixel_out,
  input logic                  frame_end
);

  // A result never appears without an earlier accepted transaction behind it.
  `FNPC_ASSERT_SAME(a_result_has_cause, $rose(out_valid), $past(in_valid && in_ready, 2))

  // With no result waiting, the pipeline always has room for a transaction.
  `FNPC_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

  // Reset empties the result queue.
  `FNPC_ASSERT_NEXT_ALWAYS(a_reset_flush, !rst_n, !out_valid)

  // A stalled result holds.
  `FNPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(pixel_out) && $stable(frame_end))

endmodule

bind four_neighbour_peak_clamp fnpc_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_fnpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pixel_out (out_chan.pixel_out),
  .frame_end (out_chan.frame_end)
);
